[rtl/core/fpts_pkg.sv]
// Shared types and constants for the temperature stepped fan PWM controller.
`default_nettype none

package fpts_pkg;

  // Duty is a fixed-point fraction of full scale
  localparam int DUTY_FRAC_BITS = 10;
  localparam int DUTY_ONE       = 1 << DUTY_FRAC_BITS;
  localparam int DUTY_W         = DUTY_FRAC_BITS + 1;

  localparam int TEMP_W         = 19;
  localparam int PERIOD_W       = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 19;

  localparam int PHASE_BITS_DEF = 16;

  // Reset values of the configuration registers
  localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RST  = 19'sd45000;
  localparam logic [DUTY_W-1:0]        MIN_DUTY_RST     = 11'd307;
  localparam logic [DUTY_W-1:0]        DUTY_STEP_RST    = 11'd51;
  localparam logic [PERIOD_W-1:0]      PERIOD_TICKS_RST = 16'd10000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_TEMP  = 2'd0,
    REG_MIN_DUTY     = 2'd1,
    REG_DUTY_STEP    = 2'd2,
    REG_PERIOD_TICKS = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_t;

  // Control handed to the PWM generator for one request
  typedef struct packed {
    logic                tick;
    logic [DUTY_W-1:0]   mapped_duty;
    logic [PERIOD_W-1:0] period;
  } pwm_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/fpts_pwm_gen.sv]
// PWM phase counter, on-time latch and fan level register.
`default_nettype none

module fpts_pwm_gen #(
  parameter int PHASE_BITS = fpts_pkg::PHASE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fpts_pkg::pwm_ctrl_t ctrl,
  output logic                   fan_level
);

  localparam int PW = fpts_pkg::PERIOD_W;
  localparam int DW = fpts_pkg::DUTY_W;
  localparam int FB = fpts_pkg::DUTY_FRAC_BITS;
  // compare width wide enough for phase + 1 and the period
  localparam int CW = (PHASE_BITS + 1 > PW + 1) ? PHASE_BITS + 1 : PW + 1;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PW-1:0]         latched_r, latched_nxt;
  logic                  level_r, level_nxt;

  logic [PW-1:0]         per;
  logic [DW+PW-1:0]      prod;
  logic [DW+PW:0]        prod_rnd;
  logic [DW+PW-FB:0]     on_raw;
  logic [PW-1:0]         on_ticks;
  logic [PHASE_BITS:0]   phase_inc;

  always_comb begin
    per       = (ctrl.period == '0) ? PW'(1) : ctrl.period;
    prod      = (DW+PW)'(ctrl.mapped_duty) * (DW+PW)'(per);
    prod_rnd  = (DW+PW+1)'(prod) + (DW+PW+1)'(fpts_pkg::DUTY_ONE >> 1);
    on_raw    = prod_rnd[DW+PW:FB];
    on_ticks  = (on_raw > (DW+PW-FB+1)'(per)) ? per : on_raw[PW-1:0];

    latched_nxt = (phase_r == '0) ? on_ticks : latched_r;
    level_nxt   = CW'(phase_r) < CW'(latched_nxt);

    phase_inc = (PHASE_BITS+1)'(phase_r) + (PHASE_BITS+1)'(1);
    phase_nxt = (CW'(phase_inc) >= CW'(per)) ? '0 : phase_inc[PHASE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      latched_r <= '0;
      level_r   <= 1'b0;
    end else if (ctrl.tick) begin
      phase_r   <= phase_nxt;
      latched_r <= latched_nxt;
      level_r   <= level_nxt;
    end
  end

  // level as it stands after the current request
  assign fan_level = ctrl.tick ? level_nxt : level_r;

endmodule

`default_nettype wire

[rtl/core/fan_pwm_temperature_stepper.sv]
// Top level of the temperature stepped fan PWM controller.
// Usage
//   Input stream (in_*): each request is either a temperature sample
//   (in_tuser = 0, reading in in_tdata, millidegrees, signed) or one PWM
//   tick (in_tuser = 1, in_tdata ignored).
//   Output stream (out_*): exactly one result per request, carrying the fan
//   pin level and the mapped output duty (Q10) after that request.
//   Configuration (cfg_*): single-cycle writes, index 0 target temperature,
//   1 minimum duty, 2 duty step, 3 period in ticks. Write only when idle.
// Timing
//   Two register stages: input register, then result register. A request
//   passes the input register into the result register, which holds it until
//   taken; one request per cycle is sustained while out_tready is high. All work
//   sits between the stages: the step add and clamp plus one 11x11 multiply,
//   rounded and offset, for samples, one 11x16 multiply and compare for ticks.
// Reset
//   Synchronous, active low: registers back to their defaults, duty at full,
//   phase and on-time at zero, both streams empty.
// Back-pressure
//   While out_tready is low the result holds, and the input register, if
//   empty, still takes one more request before in_tready drops.
`default_nettype none

module fan_pwm_temperature_stepper #(
  parameter int PHASE_BITS = fpts_pkg::PHASE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [18:0] temperature, [23:19] zero
  input  wire logic        in_tuser,   // [0] kind: 0 sample, 1 tick
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [0] fan_level, [11:1] output_duty, [15:12] zero
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [fpts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TW = fpts_pkg::TEMP_W;
  localparam int DW = fpts_pkg::DUTY_W;
  localparam int FB = fpts_pkg::DUTY_FRAC_BITS;
  localparam int SW = DW + 2;  // signed width for stepped duty before clamping

  // configuration registers
  logic signed [TW-1:0]             target_temp_r;
  logic [DW-1:0]                    min_duty_r;
  logic [DW-1:0]                    duty_step_r;
  logic [fpts_pkg::PERIOD_W-1:0]    period_ticks_r;

  // input stage
  logic                 s1_valid_r;
  fpts_pkg::item_kind_t s1_kind_r;
  logic signed [TW-1:0] s1_temp_r;

  // duty state
  logic [DW-1:0] stepped_r, stepped_nxt;
  logic [DW-1:0] mapped_r, mapped_nxt;

  // result stage
  logic          out_valid_r;
  logic          out_level_r;
  logic [DW-1:0] out_duty_r;

  logic advance, fire, is_tick;
  fpts_pkg::pwm_ctrl_t pwm_ctrl;
  logic                fan_level;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign fire      = s1_valid_r && advance;
  assign is_tick   = (s1_kind_r == fpts_pkg::KIND_TICK);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_temp_r  <= fpts_pkg::TARGET_TEMP_RST;
      min_duty_r     <= fpts_pkg::MIN_DUTY_RST;
      duty_step_r    <= fpts_pkg::DUTY_STEP_RST;
      period_ticks_r <= fpts_pkg::PERIOD_TICKS_RST;
    end else if (cfg_we) begin
      case (fpts_pkg::cfg_reg_t'(cfg_index))
        fpts_pkg::REG_TARGET_TEMP:  target_temp_r  <= signed'(cfg_wdata[TW-1:0]);
        fpts_pkg::REG_MIN_DUTY:     min_duty_r     <= cfg_wdata[DW-1:0];
        fpts_pkg::REG_DUTY_STEP:    duty_step_r    <= cfg_wdata[DW-1:0];
        fpts_pkg::REG_PERIOD_TICKS: period_ticks_r <= cfg_wdata[fpts_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // step, clamp and map the duty for a sample
  always_comb begin
    logic signed [SW-1:0] base, step, sum;
    logic [DW-1:0]        mn, span;
    logic [2*DW-1:0]      mprod;
    logic [2*DW:0]        mrnd;
    logic [DW:0]          msum;

    base = signed'(SW'(stepped_r));
    step = signed'(SW'(duty_step_r));
    sum  = base;
    if (s1_temp_r < target_temp_r) begin
      sum = base - step;
    end else if (s1_temp_r > target_temp_r) begin
      sum = base + step;
    end

    if (sum > signed'(SW'(fpts_pkg::DUTY_ONE))) begin
      stepped_nxt = DW'(fpts_pkg::DUTY_ONE);
    end else if (sum < signed'(SW'(0))) begin
      stepped_nxt = '0;
    end else begin
      stepped_nxt = sum[DW-1:0];
    end

    mn    = (min_duty_r > DW'(fpts_pkg::DUTY_ONE)) ? DW'(fpts_pkg::DUTY_ONE) : min_duty_r;
    span  = DW'(fpts_pkg::DUTY_ONE) - mn;
    mprod = (2*DW)'(span) * (2*DW)'(stepped_nxt);
    mrnd  = (2*DW+1)'(mprod) + (2*DW+1)'(fpts_pkg::DUTY_ONE >> 1);
    msum  = (DW+1)'(mn) + (DW+1)'(mrnd[2*DW:FB]);
    mapped_nxt = (stepped_nxt == '0) ? '0 : msum[DW-1:0];
  end

  assign pwm_ctrl.tick        = fire && is_tick;
  assign pwm_ctrl.mapped_duty = mapped_r;
  assign pwm_ctrl.period      = period_ticks_r;

  fpts_pwm_gen #(
    .PHASE_BITS(PHASE_BITS)
  ) u_pwm (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (pwm_ctrl),
    .fan_level (fan_level)
  );

  // control and duty state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      stepped_r   <= DW'(fpts_pkg::DUTY_ONE);
      mapped_r    <= DW'(fpts_pkg::DUTY_ONE);
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire && !is_tick) begin
        stepped_r <= stepped_nxt;
        mapped_r  <= mapped_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= fpts_pkg::item_kind_t'(in_tuser);
      s1_temp_r <= signed'(in_tdata[TW-1:0]);
    end
    if (fire) begin
      out_level_r <= fan_level;
      out_duty_r  <= is_tick ? mapped_r : mapped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_duty_r, out_level_r};

endmodule

`default_nettype wire

[rtl/core/fpts_checker.sv]
// Port-level checks for the fan PWM controller, bound to the top level.
`default_nettype none

module fpts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // duty never above full scale
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:1] <= 11'd1024)
    else $error("output duty above full scale");

  // empty result stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  // a request taken with a free path passes the input register and shows up as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing after request");

endmodule

bind fan_pwm_temperature_stepper fpts_checker u_fpts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[sim/fan_pwm_temperature_stepper_tb.sv]
// Testbench for the temperature stepped fan PWM controller: predicts every result and checks it.
`timescale 1ns / 1ps

module fan_pwm_temperature_stepper_tb;
  import fpts_pkg::*;

  // Watchdog limit for the whole run, well above the slowest correct run (about 1400
  // requests with sender gaps, sparse receiver patterns and a few long holds).
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SOAK_CYCLES   = 90;  // long receiver hold, fills both pipeline stages
  localparam int SETTLE_CYCLES = 4;   // two register stages plus margin
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 100;

  typedef struct {
    item_kind_t                kind;
    logic signed [TEMP_W-1:0]  temperature;
  } fan_req_t;

  typedef struct packed {
    logic              fan_level;
    logic [DUTY_W-1:0] output_duty;
  } fan_out_t;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;  // [18:0] temperature, [23:19] zero
  logic                  in_tuser   = 1'b0; // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;         // [0] fan_level, [11:1] output_duty
  logic                  cfg_we     = 1'b0;
  cfg_reg_t              cfg_index  = REG_TARGET_TEMP;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  fan_pwm_temperature_stepper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Controller copy: register settings and state as the block should hold them
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] set_target;
  logic [DUTY_W-1:0]        set_min_duty;
  logic [DUTY_W-1:0]        set_step;
  logic [PERIOD_W-1:0]      set_period;

  logic [DUTY_W-1:0]        st_stepped;
  logic [DUTY_W-1:0]        st_mapped;
  logic [PERIOD_W-1:0]      st_on_ticks;
  logic [PERIOD_W-1:0]      st_phase;
  logic                     st_level;

  fan_req_t requests_to_send[$];  // requests not yet taken by the block
  fan_out_t fan_outputs_due[$];   // outputs owed for requests already taken

  int failures = 0;

  // Advance the controller copy by one request and return the output it owes.
  function automatic fan_out_t step_fan_state(fan_req_t r);
    int       d;
    int       mn;
    int       per;
    int       on;
    fan_out_t res;
    if (r.kind == KIND_SAMPLE) begin
      d = int'(st_stepped);
      if (r.temperature < set_target) d -= int'(set_step);
      else if (r.temperature > set_target) d += int'(set_step);
      // any step size, clamped to 0..full
      if (d > DUTY_ONE) d = DUTY_ONE;
      if (d < 0) d = 0;
      st_stepped = DUTY_W'(d);
      // min duty above full acts as full; rounding is half-up
      mn = (int'(set_min_duty) > DUTY_ONE) ? DUTY_ONE : int'(set_min_duty);
      if (d == 0) st_mapped = '0;
      else st_mapped = DUTY_W'(mn + (((DUTY_ONE - mn) * d + DUTY_ONE / 2) >> DUTY_FRAC_BITS));
    end else begin
      // zero period behaves as a period of one tick
      per = (set_period == '0) ? 1 : int'(set_period);
      if (st_phase == '0) begin
        on = (int'(st_mapped) * per + DUTY_ONE / 2) >> DUTY_FRAC_BITS;
        if (on > per) on = per;
        st_on_ticks = PERIOD_W'(on);
      end
      st_level = (st_phase < st_on_ticks);
      // a period shortened mid-cycle wraps the phase at once
      if (int'(st_phase) + 1 >= per) st_phase = '0;
      else st_phase = st_phase + 1'b1;
    end
    res.fan_level   = st_level;
    res.output_duty = st_mapped;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. A request stays
  // on the bus until taken; valid gets one assignment per edge.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;
  bit offer;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = 1'b0;
      if (in_tvalid && in_tready) begin
        fan_outputs_due.push_back(step_fan_state(requests_to_send.pop_front()));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          // a third of the bursts run on with no gap at all
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (in_tvalid && !in_tready) offer = 1'b1;
      else if (gap_left > 0) gap_left--;
      else if (requests_to_send.size() != 0) offer = 1'b1;
      in_tvalid <= offer;
      if (offer) begin
        in_tdata <= {5'b0, requests_to_send[0].temperature};
        in_tuser <= requests_to_send[0].kind;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, changed at random intervals, with rare random
  // holds, plus one long hold once random traffic is flowing so the block backs up.
  // ---------------------------------------------------------------------------
  rx_pattern_t rx_mode      = RX_FREE;
  int          stretch_left = 0;
  int          hold_left    = 0;
  bit          soak_armed   = 1'b0;
  bit          soak_done    = 1'b0;
  bit          ready_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (soak_armed && !soak_done && in_tvalid) begin
        hold_left  = SOAK_CYCLES;
        soak_done  = 1'b1;
        ready_next = 1'b0;
      end else begin
        if (stretch_left <= 0) begin
          rx_mode      = rx_pattern_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(4, 60);
          if ($urandom_range(0, 99) == 0) hold_left = $urandom_range(20, 60);
        end else begin
          stretch_left--;
        end
        case (rx_mode)
          RX_FREE:   ready_next = 1'b1;
          RX_COIN:   ready_next = $urandom_range(0, 1);
          RX_SPARSE: ready_next = ($urandom_range(0, 4) == 0);
          default:   ready_next = ~out_tready;
        endcase
      end
      out_tready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest owed output
  // ---------------------------------------------------------------------------
  fan_out_t due;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (fan_outputs_due.size() == 0) begin
        $error("result with no request owed: out_tdata %h", out_tdata);
        failures++;
      end else begin
        due = fan_outputs_due.pop_front();
        if (out_tdata[0] !== due.fan_level) begin
          $error("fan_level: expected %0d, got %0d", due.fan_level, out_tdata[0]);
          failures++;
        end
        if (out_tdata[11:1] !== due.output_duty) begin
          $error("output_duty: expected %0d, got %0d", due.output_duty, out_tdata[11:1]);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(item_kind_t kind, int temperature);
    fan_req_t r;
    r.kind        = kind;
    r.temperature = temperature[TEMP_W-1:0];
    requests_to_send.push_back(r);
  endtask

  // Every owed output in, then a short pause for the pipeline to empty.
  task automatic wait_drained();
    while (requests_to_send.size() != 0 || fan_outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_TARGET_TEMP: set_target   = value[TEMP_W-1:0];
      REG_MIN_DUTY:    set_min_duty = value[DUTY_W-1:0];
      REG_DUTY_STEP:   set_step     = value[DUTY_W-1:0];
      default:         set_period   = value[PERIOD_W-1:0];
    endcase
  endtask

  // Registers only change with the block idle.
  task automatic apply_settings(int target, int min_duty, int step, int period);
    wait_drained();
    write_reg(REG_TARGET_TEMP, target);
    write_reg(REG_MIN_DUTY, min_duty);
    write_reg(REG_DUTY_STEP, step);
    write_reg(REG_PERIOD_TICKS, period);
  endtask

  // Mostly ticks; samples mostly hover round the target so the stepped duty
  // walks up and down through its range, the rest span -40000 to 150000.
  task automatic add_random_requests(int n);
    int pick;
    int t;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) t = int'(set_target) + int'($urandom_range(0, 600)) - 300;
      else if (pick == 5) t = int'(set_target);
      else t = -40000 + int'($urandom_range(0, 190000));
      push_req(($urandom_range(0, 9) < 6) ? KIND_TICK : KIND_SAMPLE, t);
    end
  endtask

  int rnd_min;
  int rnd_step;
  int rnd_period;
  int pick;

  initial begin
    set_target   = TARGET_TEMP_RST;
    set_min_duty = MIN_DUTY_RST;
    set_step     = DUTY_STEP_RST;
    set_period   = PERIOD_TICKS_RST;
    st_stepped   = DUTY_W'(DUTY_ONE);
    st_mapped    = DUTY_W'(DUTY_ONE);
    st_on_ticks  = '0;
    st_phase     = '0;
    st_level     = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: equal, above and below target, the two readings either
    // side of target, sign boundary, and the extremes of the 19-bit field.
    push_req(KIND_TICK, 0);
    push_req(KIND_SAMPLE, 45000);
    push_req(KIND_SAMPLE, 150000);
    push_req(KIND_SAMPLE, -40000);
    push_req(KIND_SAMPLE, 44999);
    push_req(KIND_SAMPLE, 45001);
    push_req(KIND_SAMPLE, -1);
    push_req(KIND_SAMPLE, 0);
    push_req(KIND_SAMPLE, -262144);
    push_req(KIND_SAMPLE, 262143);
    push_req(KIND_TICK, 0);
    push_req(KIND_TICK, -1);

    // Oversized step and min duty, zero period; the phase left over from the
    // long reset period has to wrap on the first tick.
    apply_settings(45000, 2047, 2047, 0);
    push_req(KIND_SAMPLE, -40000);
    push_req(KIND_TICK, 0);
    push_req(KIND_SAMPLE, 150000);
    push_req(KIND_TICK, 0);
    push_req(KIND_SAMPLE, 45000);

    // Half-way duty on a one-tick period: on-time rounds a half upwards.
    apply_settings(0, 0, 512, 1);
    push_req(KIND_SAMPLE, -1);
    push_req(KIND_TICK, 0);
    push_req(KIND_SAMPLE, -1);
    push_req(KIND_TICK, 0);
    push_req(KIND_SAMPLE, 1);

    soak_armed = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        apply_settings(-40000, 0, 1, 1);
      end else if (p == 1) begin
        apply_settings(150000, 1024, 1024, 65535);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) rnd_min = $urandom_range(1025, 2047);
        else if (pick == 1) rnd_min = 0;
        else if (pick == 2) rnd_min = DUTY_ONE;
        else rnd_min = $urandom_range(0, 1024);
        pick = $urandom_range(0, 9);
        if (pick == 0) rnd_step = $urandom_range(1024, 2047);
        else if (pick == 1) rnd_step = 0;
        else rnd_step = $urandom_range(1, 128);
        pick = $urandom_range(0, 9);
        if (pick == 0) rnd_period = 0;
        else if (pick == 1) rnd_period = 1;
        else if (pick == 2) rnd_period = $urandom_range(1000, 65535);
        else rnd_period = $urandom_range(2, 40);
        apply_settings(-40000 + int'($urandom_range(0, 190000)), rnd_min, rnd_step, rnd_period);
      end
      add_random_requests(PHASE_ITEMS);
    end

    wait_drained();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
